// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL. Each macro expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/blrc_pkg.sv =====
// ----------------------------------------------------------------------------
// blrc_pkg
// Types and constants for the boot loader response frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package blrc_pkg;

  localparam int TIMER_BITS = 17;
  localparam int TIMEOUT_W  = 17;
  localparam int COUNT_W    = 9;

  localparam logic [7:0] SLIP_END  = 8'hC0;
  localparam logic [7:0] DIR_REPLY = 8'h01;
  localparam logic [7:0] STATUS_OK = 8'h00;

  localparam logic [7:0] LEN_DEFAULT     = 8'd4;
  localparam logic [8:0] LEN_POS         = 9'd3;
  localparam logic [8:0] BODY_START      = 9'd9;
  localparam logic [9:0] FRAME_OVERHEAD  = 10'd10;
  localparam logic [9:0] STATUS_OFF      = 10'd5;
  localparam logic [9:0] STATUS2_OFF     = 10'd6;
  localparam logic [9:0] END_OFF         = 10'd9;
  // Longest frame is 10 + 255 bytes, so the count never passes this.
  localparam logic [8:0] COUNT_MAX       = 9'd265;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_OK         = 2'd0,
    OUT_INCOMPLETE = 2'd1,
    OUT_BAD_FRAME  = 2'd2
  } outcome_t;

  typedef enum logic {
    KIND_BODY  = 1'b0,
    KIND_FINAL = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] outcome;
    logic [7:0] body_index;
    logic [7:0] body_value;
  } result_t;

endpackage

`default_nettype wire

// ===== design/boot_loader_response_checker_top.sv =====
// ----------------------------------------------------------------------------
// boot_loader_response_checker_top
// Checks one serial boot loader response frame, one received byte per word.
// ----------------------------------------------------------------------------
//
//  Port group  Dir  tdata fields (low bit up)                    tuser
//  s_axis      in   rx_byte, expected_opcode, timeout_ms, pad    command
//  m_axis      out  body_value, body_index, outcome, pad         result_kind
//
// Every input word passes through the input register and the check logic into
// the output buffer, so a word is accepted each cycle while s_axis_tready is high.
// Results go to a two-entry output buffer (head plus skid register), and
// s_axis_tready depends only on registers: it drops only when both the input
// register and the skid register are full.
// Reset is synchronous and clears the control state and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module boot_loader_response_checker_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // rx_byte [7:0], expected_opcode [15:8], timeout_ms [32:16], zero [39:33]
  input  wire logic [39:0] s_axis_tdata,
  // command [1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // body_value [7:0], body_index [15:8], outcome [17:16], zero [23:18]
  output logic [23:0]      m_axis_tdata,
  // result_kind [0]
  output logic             m_axis_tuser
);
  import blrc_pkg::*;

  localparam int SAT_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
  localparam logic [SAT_W-1:0] TIMER_MAX_W = SAT_W'({TIMER_BITS{1'b1}});

  // Input register.
  logic                 in_valid;
  logic [1:0]           in_cmd;
  logic [7:0]           in_byte;
  logic [7:0]           in_opcode;
  logic [TIMEOUT_W-1:0] in_timeout;

  // Transaction state.
  logic                  busy, busy_next;
  logic [COUNT_W-1:0]    byte_count, byte_count_next;
  logic [7:0]            frame_length, frame_length_next;
  logic [7:0]            opcode_wanted, opcode_wanted_next;
  logic [TIMER_BITS-1:0] time_left, time_left_next;
  logic                  frame_good, frame_good_next;

  // Output buffer.
  logic    out_valid, skid_valid;
  result_t out_res, skid_res;

  logic    advance, push, pop;
  result_t res;

  logic [SAT_W-1:0]      t_wide;
  logic [TIMER_BITS-1:0] time_start;
  logic [TIMER_BITS-1:0] time_dec;
  logic [7:0]            len_eff;
  logic [9:0]            p_ext, len_ext;
  logic                  fault;

  assign s_axis_tready = !in_valid || !skid_valid;
  assign advance       = in_valid && !skid_valid;
  assign pop           = out_valid && m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tdata  = {6'd0, out_res.outcome, out_res.body_index, out_res.body_value};

  // Timeout saturates to what the timer holds.
  assign t_wide     = SAT_W'(in_timeout);
  assign time_start = (t_wide > TIMER_MAX_W) ? TIMER_MAX_W[TIMER_BITS-1:0]
                                             : t_wide[TIMER_BITS-1:0];
  assign time_dec   = (time_left != '0) ? time_left - TIMER_BITS'(1) : '0;

  // The length byte counts from the word that carries it.
  assign len_eff = (byte_count == LEN_POS) ? in_byte : frame_length;
  assign p_ext   = 10'(byte_count);
  assign len_ext = 10'(len_eff);

  always_comb begin
    fault = 1'b0;
    if (byte_count == 9'd0 && in_byte != SLIP_END)      fault = 1'b1;
    if (byte_count == 9'd1 && in_byte != DIR_REPLY)     fault = 1'b1;
    if (byte_count == 9'd2 && in_byte != opcode_wanted) fault = 1'b1;
    if (p_ext == len_ext + STATUS_OFF && in_byte != STATUS_OK)  fault = 1'b1;
    if (p_ext == len_ext + STATUS2_OFF && in_byte != STATUS_OK) fault = 1'b1;
    if (p_ext == len_ext + END_OFF && in_byte != SLIP_END)      fault = 1'b1;
  end

  always_comb begin
    busy_next          = busy;
    byte_count_next    = byte_count;
    frame_length_next  = frame_length;
    opcode_wanted_next = opcode_wanted;
    time_left_next     = time_left;
    frame_good_next    = frame_good;
    push               = 1'b0;
    res                = '0;
    if (advance) begin
      unique case (in_cmd)
        CMD_START: begin
          busy_next          = 1'b1;
          byte_count_next    = '0;
          frame_length_next  = LEN_DEFAULT;
          opcode_wanted_next = in_opcode;
          time_left_next     = time_start;
          frame_good_next    = 1'b1;
          if (time_start == '0) begin
            busy_next   = 1'b0;
            push        = 1'b1;
            res.kind    = KIND_FINAL;
            res.outcome = OUT_INCOMPLETE;
          end
        end
        CMD_BYTE: begin
          if (busy) begin
            frame_length_next = len_eff;
            frame_good_next   = frame_good && !fault;
            byte_count_next   = byte_count + COUNT_W'(1);
            if (p_ext + 10'd1 >= FRAME_OVERHEAD + len_ext) begin
              busy_next   = 1'b0;
              push        = 1'b1;
              res.kind    = KIND_FINAL;
              res.outcome = (frame_good && !fault) ? OUT_OK : OUT_BAD_FRAME;
            end else if (byte_count >= BODY_START &&
                         p_ext + 10'd1 <= len_ext + STATUS_OFF) begin
              push           = 1'b1;
              res.kind       = KIND_BODY;
              res.body_value = in_byte;
              res.body_index = 8'(byte_count - BODY_START);
            end
          end
        end
        CMD_TICK: begin
          if (busy) begin
            time_left_next = time_dec;
            if (time_dec == '0) begin
              busy_next   = 1'b0;
              push        = 1'b1;
              res.kind    = KIND_FINAL;
              res.outcome = OUT_INCOMPLETE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      busy          <= 1'b0;
      byte_count    <= '0;
      frame_length  <= LEN_DEFAULT;
      opcode_wanted <= '0;
      time_left     <= '0;
      frame_good    <= 1'b1;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid   <= 1'b1;
        in_cmd     <= s_axis_tuser;
        in_byte    <= s_axis_tdata[7:0];
        in_opcode  <= s_axis_tdata[15:8];
        in_timeout <= s_axis_tdata[32:16];
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      busy          <= busy_next;
      byte_count    <= byte_count_next;
      frame_length  <= frame_length_next;
      opcode_wanted <= opcode_wanted_next;
      time_left     <= time_left_next;
      frame_good    <= frame_good_next;

      // Head register refills from the skid first to keep order.
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          out_valid  <= 1'b1;
          skid_valid <= push;
          if (push) begin
            skid_res <= res;
          end
        end else begin
          out_valid <= push;
          if (push) begin
            out_res <= res;
          end
        end
      end else if (push) begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  `ASSERT_SAME(a_skid_behind_head, skid_valid, out_valid, "skid full while head empty")
  `ASSERT_SAME(a_count_in_range, 1'b1, byte_count <= COUNT_MAX, "byte count past longest frame")
  `ASSERT_NEXT(a_final_ends_txn, push && res.kind == KIND_FINAL, !busy,
               "still busy after final result")
  `ASSERT_SAME(a_body_in_frame, push && res.kind == KIND_BODY,
               10'(res.body_index) + STATUS_OFF <= 10'(frame_length_next),
               "body byte beyond frame body")

endmodule

`default_nettype wire

// ===== verif/boot_loader_response_checker_top_tb.sv =====
// ----------------------------------------------------------------------------
// boot_loader_response_checker_top_tb
// Streams received bytes, start words and millisecond ticks into the response
// checker and tracks each frame in a model of its own. Every result word is
// compared with the oldest predicted one. The run has four pacing phases with
// different input gaps and output stalls, and drains between them.
// ----------------------------------------------------------------------------
module boot_loader_response_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blrc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int HANG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  rx_byte;
    logic [7:0]  opcode;
    logic [16:0] timeout_ms;
  } in_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  boot_loader_response_checker_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  in_word_t    queued_words[$];
  result_t     awaited_reports[$];
  in_word_t    on_bus;
  int unsigned counted_words = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fault_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned starts_seen = 0;
  int unsigned body_words = 0;
  int unsigned outcome_tally[3] = '{0, 0, 0};
  bit          long_frame_done = 1'b0;

  // Tracked checker state.
  bit                    busy_q = 1'b0;
  int unsigned           byte_count_q = 0;
  int unsigned           frame_len_q = LEN_DEFAULT;
  logic [7:0]            opcode_q = '0;
  logic [TIMER_BITS-1:0] timer_q = '0;
  bit                    frame_good_q = 1'b1;

  function automatic void log_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  function automatic void add_final(input outcome_t oc);
    result_t r;
    r.kind = KIND_FINAL;
    r.outcome = oc;
    r.body_index = '0;
    r.body_value = '0;
    awaited_reports.push_back(r);
    busy_q = 1'b0;
  endfunction

  // Advances the tracked state by one accepted input word.
  function automatic void follow_response_word(input in_word_t w);
    int unsigned p;
    int unsigned len;
    longint unsigned t;
    result_t r;
    case (w.cmd)
      CMD_START: begin
        t = w.timeout_ms;
        if (t > (64'd1 << TIMER_BITS) - 1) t = (64'd1 << TIMER_BITS) - 1;
        starts_seen++;
        busy_q = 1'b1;
        byte_count_q = 0;
        frame_len_q = LEN_DEFAULT;
        opcode_q = w.opcode;
        timer_q = t[TIMER_BITS-1:0];
        frame_good_q = 1'b1;
        if (t == 0) add_final(OUT_INCOMPLETE);
      end
      CMD_TICK: begin
        if (busy_q) begin
          if (timer_q != 0) timer_q = timer_q - 1'b1;
          if (timer_q == 0) add_final(OUT_INCOMPLETE);
        end
      end
      CMD_BYTE: begin
        if (busy_q) begin
          p = byte_count_q;
          if (p == 0 && w.rx_byte != SLIP_END) frame_good_q = 1'b0;
          if (p == 1 && w.rx_byte != DIR_REPLY) frame_good_q = 1'b0;
          if (p == 2 && w.rx_byte != opcode_q) frame_good_q = 1'b0;
          if (p == LEN_POS) frame_len_q = w.rx_byte;
          len = frame_len_q;
          if (p == len + STATUS_OFF && w.rx_byte != STATUS_OK) frame_good_q = 1'b0;
          if (p == len + STATUS2_OFF && w.rx_byte != STATUS_OK) frame_good_q = 1'b0;
          if (p == len + END_OFF && w.rx_byte != SLIP_END) frame_good_q = 1'b0;
          byte_count_q = (p + 1) & 32'h1FF;
          if (p + 1 >= FRAME_OVERHEAD + len) begin
            add_final(frame_good_q ? OUT_OK : OUT_BAD_FRAME);
          end else if (p >= BODY_START && p + 1 <= len + STATUS_OFF) begin
            r.kind = KIND_BODY;
            r.outcome = OUT_OK;
            r.body_index = 8'(p - BODY_START);
            r.body_value = w.rx_byte;
            awaited_reports.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_report(input logic kind_bit, input logic [23:0] data);
    result_t e;
    if (awaited_reports.size() == 0) begin
      log_fault($sformatf("unexpected word kind=%0b data=%h", kind_bit, data));
    end else begin
      e = awaited_reports.pop_front();
      if (kind_bit !== e.kind || data[7:0] !== e.body_value || data[15:8] !== e.body_index ||
          data[17:16] !== e.outcome || data[23:18] !== 6'd0) begin
        log_fault($sformatf("exp kind=%0b value=%h index=%0d outcome=%0d, got kind=%0b value=%h index=%0d outcome=%0d pad=%h",
                            e.kind, e.body_value, e.body_index, e.outcome, kind_bit,
                            data[7:0], data[15:8], data[17:16], data[23:18]));
      end
    end
    if (kind_bit === KIND_BODY) body_words++;
    else if (data[17:16] < 3) outcome_tally[data[17:16]]++;
  endfunction

  // Input side: present the next queued word unless this cycle is a gap.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) follow_response_word(on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (queued_words.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          on_bus = queued_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {7'd0, on_bus.timeout_ms, on_bus.opcode, on_bus.rx_byte};
          s_axis_tuser <= on_bus.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: random backpressure, check every accepted word.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tuser, m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == HANG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
               HANG_LIMIT, awaited_reports.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] cmd, input logic [7:0] rx, input logic [7:0] op,
                           input logic [16:0] tmo, input bit counted);
    in_word_t w;
    w.cmd = cmd;
    w.rx_byte = rx;
    w.opcode = op;
    w.timeout_ms = tmo;
    queued_words.push_back(w);
    if (counted) counted_words++;
  endtask

  task automatic push_tick(input bit counted);
    push_item(CMD_TICK, 8'($urandom), 8'($urandom), 17'($urandom), counted);
  endtask

  function automatic logic [16:0] big_timeout();
    if ($urandom_range(9) == 0) return 17'h1FFFF;
    return 17'($urandom_range(1000, 131071));
  endfunction

  // Start word plus the first cut bytes of a frame of body length len, with ticks
  // mixed in at tick_pct percent. When mangle is set one checked byte (start,
  // direction, opcode, status or end) is corrupted if it lies within the cut.
  task automatic queue_transaction(input logic [7:0] op, input logic [16:0] tmo,
                                   input int unsigned len, input bit mangle,
                                   input int unsigned cut, input int unsigned tick_pct);
    int unsigned bad_pos;
    logic [7:0] b;
    case ($urandom_range(5))
      0: bad_pos = 0;
      1: bad_pos = 1;
      2: bad_pos = 2;
      3: bad_pos = len + STATUS_OFF;
      4: bad_pos = len + STATUS2_OFF;
      default: bad_pos = len + END_OFF;
    endcase
    push_item(CMD_START, 8'($urandom), op, tmo, 1'b1);
    for (int unsigned p = 0; p < len + FRAME_OVERHEAD && p < cut; p++) begin
      if ($urandom_range(99) < tick_pct) push_tick(1'b1);
      if (p == 0 || p == len + END_OFF) b = SLIP_END;
      else if (p == 1) b = DIR_REPLY;
      else if (p == 2) b = op;
      else if (p == LEN_POS) b = 8'(len);
      else if (p == len + STATUS_OFF || p == len + STATUS2_OFF) b = STATUS_OK;
      else b = 8'($urandom);
      if (mangle && p == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      push_item(CMD_BYTE, b, 8'($urandom), 17'($urandom), 1'b1);
    end
  endtask

  task automatic queue_random_transaction(input bit want_long);
    int unsigned r;
    int unsigned len;
    int unsigned tmo;
    logic [7:0] op;
    r = $urandom_range(99);
    op = 8'($urandom);
    len = ($urandom_range(99) < 80) ? $urandom_range(12) : $urandom_range(13, 60);
    if (want_long) begin
      queue_transaction(op, big_timeout(), 255, 1'b0, 265, 2);
      long_frame_done = 1'b1;
    end else if (r < 58) begin
      queue_transaction(op, big_timeout(), len, 1'b0, len + FRAME_OVERHEAD, 3);
    end else if (r < 74) begin
      queue_transaction(op, big_timeout(), len, 1'b1, len + FRAME_OVERHEAD, 3);
    end else if (r < 84) begin
      // Short timeout with frequent ticks; trailing ticks make sure it expires.
      tmo = $urandom_range(1, 40);
      queue_transaction(op, 17'(tmo), len, 1'b0, len + FRAME_OVERHEAD, 25);
      repeat (tmo) push_tick(1'b0);
    end else if (r < 92) begin
      // Cut short; the next start word drops it.
      queue_transaction(op, big_timeout(), len, $urandom_range(1), $urandom_range(1, len + 9), 3);
    end else if (r < 96) begin
      push_item(CMD_START, 8'($urandom), op, 17'd0, 1'b1);
      repeat ($urandom_range(1, 3)) push_item(CMD_BYTE, SLIP_END, op, 17'($urandom), 1'b0);
    end else begin
      repeat ($urandom_range(1, 4))
        push_item(2'($urandom_range(CMD_UNUSED)), 8'($urandom), 8'($urandom),
                  17'($urandom), 1'b0);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (queued_words.size() != 0 || s_axis_tvalid || awaited_reports.size() != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 59; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 59; end
        default: begin send_gap_pct = 27; recv_stall_pct = 27; end
      endcase
      if (ph == 0) begin
        push_item(CMD_START, 8'h00, 8'hFF, 17'd0, 1'b1);        // zero timeout
        push_item(CMD_BYTE, SLIP_END, 8'h00, 17'd0, 1'b0);      // idle, ignored
        push_item(CMD_TICK, 8'hFF, 8'hFF, 17'h1FFFF, 1'b0);     // idle, ignored
        push_item(CMD_UNUSED, 8'hFF, 8'hFF, 17'h1FFFF, 1'b0);   // reserved command
        push_item(CMD_START, 8'hFF, 8'h00, 17'd2, 1'b1);
        push_tick(1'b1);
        push_tick(1'b1);
        push_tick(1'b1);                                        // tick after expiry
        push_item(CMD_START, 8'h00, 8'h5A, 17'd500, 1'b1);
        push_item(CMD_BYTE, SLIP_END, 8'h00, 17'd0, 1'b1);
        // Restart while busy with the largest timeout, then a clean frame.
        queue_transaction(8'hFF, 17'h1FFFF, 5, 1'b0, 15, 0);
      end
      while (counted_words < (ph + 1) * ITEMS_PER_PHASE)
        queue_random_transaction(ph == 2 && !long_frame_done);
      // Sender holds off here until every predicted result has come back.
      wait_drained();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Coverage: %0d transactions, %0d input words, %0d body words over four pacing phases",
             starts_seen, counted_words, body_words);
    $display("Outcomes: ok %0d, incomplete %0d, bad frame %0d; %0d mismatches",
             outcome_tally[0], outcome_tally[1], outcome_tally[2], fault_count);
    if (fault_count == 0 && awaited_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/blrc_pkg.sv
design/boot_loader_response_checker_top.sv
verif/boot_loader_response_checker_top_tb.sv
